// ===== src/zmp_pkg.sv =====
// shared types and constants for the zero moment point estimator
package zmp_pkg;

  // configuration register indexes
  localparam logic [0:0] CfgClampHalfWidth = 1'b0;
  localparam logic [0:0] CfgSmoothingGain  = 1'b1;

  localparam logic [30:0] ClampResetValue = 31'd2294;
  localparam logic [16:0] GainResetValue  = 17'd16384;

  localparam logic signed [31:0] SMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMin = 32'sh8000_0000;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = SMax;
    end else if (v < -66'sd2147483648) begin
      r = SMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/zmp_div.sv =====
// shared sign-magnitude restoring divider, one quotient bit per cycle, saturating
module zmp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        nneg_i,
  input  logic [63:0] nmag_i,
  input  logic        dneg_i,
  input  logic [32:0] dmag_i,
  output logic        done_o,
  output logic signed [31:0] quo_o
);

  logic [63:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] den_q;
  logic        neg_q, nneg_q;
  logic [6:0]  cnt_q;
  logic        busy_q, zden_q;
  logic [33:0] trial;
  logic [31:0] qsat;

  // one restoring step
  always_comb begin
    trial = {rem_q, num_q[63]} - {1'b0, den_q};
    num_d = {num_q[62:0], ~trial[33]};
    rem_d = trial[33] ? {rem_q[31:0], num_q[63]} : trial[32:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
        num_q  <= nmag_i;
        rem_q  <= '0;
        den_q  <= dmag_i;
        zden_q <= (dmag_i == '0);
        nneg_q <= nneg_i;
        neg_q  <= nneg_i ^ dneg_i;
      end else if (busy_q) begin
        if (zden_q || cnt_q == 7'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          num_q <= num_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - 7'd1;
        end
      end
    end
  end

  // saturate the quotient by sign
  always_comb begin
    qsat = '0;
    if (zden_q) begin
      if (num_q == '0) qsat = '0;
      else qsat = nneg_q ? zmp_pkg::SMin : zmp_pkg::SMax;
    end else if (neg_q) begin
      if (num_q >= 64'h8000_0000) qsat = zmp_pkg::SMin;
      else qsat = 32'(-num_q[31:0]);
    end else begin
      if (num_q > 64'h7FFF_FFFF) qsat = zmp_pkg::SMax;
      else qsat = num_q[31:0];
    end
  end
  assign quo_o = qsat;

endmodule

// ===== src/zmp_from_foot_wrenches_unit.sv =====
// zero moment point estimator top level
// Usage: items arrive on in_valid_i / in_stall_o, one left-foot item
// (foot_side 0) then one right-foot item (foot_side 1) per sample. A left
// item updates the held left-foot state and produces no result; a right
// item produces one result on out_valid_o / out_stall_i with the filtered
// zero moment point and the contact state.
// Processing is paced by the single shared 64-bit restoring divider, one quotient
// bit per cycle. A foot in contact takes two divisions plus rotation and
// combine; both feet in contact add two weighted-average divisions; clamp and
// filter follow. A left item keeps in_stall_o high while it is processed.
// The next item can be taken in the cycle after the result leaves; no item
// is taken before the block is through with the previous one.
// A shared 33x33 multiplier serves the rotation, weighting and filter products.
// in_stall_o is high while the block works and while a result waits; if the
// receiver stalls, the result holds until taken. Reset clears the estimate and
// left state and loads the register reset values; registers are to be written
// while the block is idle, which the block itself does not enforce.
module zmp_from_foot_wrenches_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        foot_side_i,
  input  logic signed [31:0] torque_x_i,
  input  logic signed [31:0] torque_y_i,
  input  logic signed [31:0] normal_force_i,
  input  logic signed [17:0] rot_xx_i,
  input  logic signed [17:0] rot_xy_i,
  input  logic signed [17:0] rot_yx_i,
  input  logic signed [17:0] rot_yy_i,
  input  logic signed [31:0] foot_pos_x_i,
  input  logic signed [31:0] foot_pos_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] zmp_x_o,
  output logic signed [31:0] zmp_y_o,
  output logic [1:0]  contact_state_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIVX, S_WDIVX, S_DIVY, S_WDIVY,
    S_R0, S_R1, S_RSUMX, S_R2, S_R3, S_RSUMY,
    S_CMB, S_W0, S_W1, S_WDX, S_WWX, S_W2, S_W3, S_WDY, S_WWY,
    S_FX, S_FXM, S_FXS, S_FY, S_FYM, S_FYS, S_OUT
  } state_e;

  state_e state_q;

  logic [30:0] clamp_q;
  logic [16:0] gain_q;
  logic signed [31:0] est_x_q, est_y_q;
  logic signed [31:0] lcx_q, lcy_q, lf_q;
  logic        lc_q;

  // captured item
  logic        side_q;
  logic signed [31:0] tx_q, ty_q, fz_q, px_q, py_q;
  logic signed [17:0] rxx_q, rxy_q, ryx_q, ryy_q;
  logic signed [31:0] cx_q, cy_q, wx_q, wy_q, zx_q, zy_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] p1_q;
  logic signed [32:0] diff_q;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  assign prod = ma * mb;

  // shared divider
  logic        dstart;
  logic        dnneg, ddneg, ddone;
  logic [63:0] dnmag;
  logic [32:0] ddmag;
  logic signed [31:0] dquo;

  zmp_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dstart),
    .nneg_i(dnneg), .nmag_i(dnmag), .dneg_i(ddneg), .dmag_i(ddmag),
    .done_o(ddone), .quo_o(dquo)
  );

  logic [32:0] fzmag;
  logic [31:0] txmag, tymag;
  logic signed [32:0] den;
  logic signed [65:0] wsum;
  logic [65:0] wmag;
  assign fzmag = fz_q[31] ? 33'(-{fz_q[31], fz_q}) : {1'b0, fz_q};
  assign txmag = tx_q[31] ? 32'(-tx_q) : tx_q;
  assign tymag = ty_q[31] ? 32'(-ty_q) : ty_q;
  assign den   = 33'(lf_q) + 33'(fz_q);
  assign wsum  = p1_q + prod;
  assign wmag  = acc_q[65] ? 66'(-acc_q) : acc_q;

  // clamp and filter datapath, shared between axes
  logic        xsel;
  logic signed [31:0] est_sel, z_sel;
  logic signed [33:0] hi, lo, zc, diff;
  logic signed [65:0] fsum;
  assign xsel    = (state_q == S_FX || state_q == S_FXM || state_q == S_FXS);
  assign est_sel = xsel ? est_x_q : est_y_q;
  assign z_sel   = xsel ? zx_q : zy_q;
  assign hi = 34'(est_sel) + 34'(signed'({1'b0, clamp_q}));
  assign lo = 34'(est_sel) - 34'(signed'({1'b0, clamp_q}));
  always_comb begin
    zc = 34'(z_sel);
    if (zc >= hi) zc = hi;
    if (zc <= lo) zc = lo;
    diff = zc - 34'(est_sel);
  end
  assign fsum = 66'(est_sel) + (acc_q >>> 16);

  // operand selection for multiplier and divider
  always_comb begin
    ma = '0;
    mb = '0;
    dstart = 1'b0;
    dnneg = 1'b0;
    dnmag = '0;
    ddneg = fz_q[31];
    ddmag = fzmag;
    case (state_q)
      S_DIVX: begin
        dstart = 1'b1;
        dnneg  = (ty_q > 0);
        dnmag  = {16'd0, tymag, 16'd0};
      end
      S_DIVY: begin
        dstart = 1'b1;
        dnneg  = tx_q[31];
        dnmag  = {16'd0, txmag, 16'd0};
      end
      S_R0: begin ma = 33'(rxx_q); mb = 33'(cx_q); end
      S_R1: begin ma = 33'(rxy_q); mb = 33'(cy_q); end
      S_R2: begin ma = 33'(ryx_q); mb = 33'(cx_q); end
      S_R3: begin ma = 33'(ryy_q); mb = 33'(cy_q); end
      S_W0, S_W2: begin
        ma = 33'((state_q == S_W0) ? lcx_q : lcy_q);
        mb = 33'(lf_q);
      end
      S_W1, S_W3: begin
        ma = 33'((state_q == S_W1) ? wx_q : wy_q);
        mb = 33'(fz_q);
      end
      S_WDX, S_WDY: begin
        dstart = 1'b1;
        dnneg = acc_q[65];
        dnmag = wmag[63:0];
        ddneg = den[32];
        ddmag = den[32] ? 33'(-den) : den;
      end
      S_FXM, S_FYM: begin ma = {16'd0, gain_q}; mb = diff_q; end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clamp_q     <= zmp_pkg::ClampResetValue;
      gain_q      <= zmp_pkg::GainResetValue;
      est_x_q     <= '0;
      est_y_q     <= '0;
      lcx_q       <= '0;
      lcy_q       <= '0;
      lf_q        <= '0;
      lc_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          zmp_pkg::CfgClampHalfWidth: clamp_q <= cfg_data_i;
          zmp_pkg::CfgSmoothingGain:  gain_q  <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            side_q <= foot_side_i;
            tx_q <= torque_x_i; ty_q <= torque_y_i; fz_q <= normal_force_i;
            rxx_q <= rot_xx_i; rxy_q <= rot_xy_i;
            ryx_q <= rot_yx_i; ryy_q <= rot_yy_i;
            px_q <= foot_pos_x_i; py_q <= foot_pos_y_i;
            wx_q <= '0; wy_q <= '0;
            state_q <= (normal_force_i != '0) ? S_DIVX : S_CMB;
          end
        end
        S_DIVX:  state_q <= S_WDIVX;
        S_WDIVX: if (ddone) begin cx_q <= dquo; state_q <= S_DIVY; end
        S_DIVY:  state_q <= S_WDIVY;
        S_WDIVY: if (ddone) begin cy_q <= dquo; state_q <= S_R0; end
        S_R0: begin acc_q <= prod; state_q <= S_R1; end
        S_R1: begin acc_q <= acc_q + prod; state_q <= S_RSUMX; end
        S_RSUMX: begin
          wx_q <= zmp_pkg::sat32(66'(px_q) + (acc_q >>> 16));
          state_q <= S_R2;
        end
        S_R2: begin acc_q <= prod; state_q <= S_R3; end
        S_R3: begin acc_q <= acc_q + prod; state_q <= S_RSUMY; end
        S_RSUMY: begin
          wy_q <= zmp_pkg::sat32(66'(py_q) + (acc_q >>> 16));
          state_q <= S_CMB;
        end
        S_CMB: begin
          if (!side_q) begin
            lc_q  <= (fz_q != '0);
            lf_q  <= fz_q;
            lcx_q <= wx_q;
            lcy_q <= wy_q;
            state_q <= S_IDLE;
          end else if (lc_q && fz_q != '0) begin
            state_q <= S_W0;
          end else begin
            if (lc_q) begin zx_q <= lcx_q; zy_q <= lcy_q; end
            else begin zx_q <= wx_q; zy_q <= wy_q; end
            state_q <= S_FX;
          end
        end
        // weighted sums are registered before they reach the divider
        S_W0: begin p1_q <= prod; state_q <= S_W1; end
        S_W1: begin acc_q <= wsum; state_q <= S_WDX; end
        S_WDX: state_q <= S_WWX;
        S_WWX: if (ddone) begin zx_q <= dquo; state_q <= S_W2; end
        S_W2: begin p1_q <= prod; state_q <= S_W3; end
        S_W3: begin acc_q <= wsum; state_q <= S_WDY; end
        S_WDY: state_q <= S_WWY;
        S_WWY: if (ddone) begin zy_q <= dquo; state_q <= S_FX; end
        // clamp, gain product and update per axis
        S_FX: begin diff_q <= diff[32:0]; state_q <= S_FXM; end
        S_FXM: begin acc_q <= prod; state_q <= S_FXS; end
        S_FXS: begin est_x_q <= zmp_pkg::sat32(fsum); state_q <= S_FY; end
        S_FY: begin diff_q <= diff[32:0]; state_q <= S_FYM; end
        S_FYM: begin acc_q <= prod; state_q <= S_FYS; end
        S_FYS: begin
          est_y_q <= zmp_pkg::sat32(fsum);
          zmp_x_o <= est_x_q;
          zmp_y_o <= zmp_pkg::sat32(fsum);
          contact_state_o <= {fz_q != '0, lc_q};
          out_valid_o <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result is only shown in the output state
  a_valid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_OUT) else $error("valid outside output state");
  // no item is taken while a result waits
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("item taken with result pending");
  // divider finishes only in a wait state
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddone |-> (state_q == S_WDIVX || state_q == S_WDIVY
               || state_q == S_WWX || state_q == S_WWY))
    else $error("divider done out of sequence");
  // a left item produces no result
  a_left_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMB && !side_q) |=> !out_valid_o)
    else $error("left item produced a result");
`endif

endmodule

// ===== tb/zmp_checker.sv =====
// watches the item channels, predicts each zero moment point result and compares
module zmp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               foot_side_i,
  input  logic signed [31:0] torque_x_i,
  input  logic signed [31:0] torque_y_i,
  input  logic signed [31:0] normal_force_i,
  input  logic signed [17:0] rot_xx_i,
  input  logic signed [17:0] rot_xy_i,
  input  logic signed [17:0] rot_yx_i,
  input  logic signed [17:0] rot_yy_i,
  input  logic signed [31:0] foot_pos_x_i,
  input  logic signed [31:0] foot_pos_y_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] zmp_x_i,
  input  logic signed [31:0] zmp_y_i,
  input  logic [1:0]         contact_state_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] zx;
    logic signed [31:0] zy;
    logic [1:0]         contact;
  } zmp_result_t;

  zmp_result_t zmp_expected_q[$];

  // model copy of registers and state
  logic [30:0]        half_width;
  logic [16:0]        gain;
  logic signed [31:0] est_x, est_y;
  logic signed [31:0] left_x, left_y, left_fz;
  logic               left_touch;

  function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return zmp_pkg::SMax;
    if (v < -66'sd2147483648) return zmp_pkg::SMin;
    return v[31:0];
  endfunction

  function automatic logic [65:0] magnitude(input logic signed [65:0] v);
    return v < 0 ? -v : v;
  endfunction

  // truncating signed divide with saturation, sign-magnitude operands
  function automatic logic signed [31:0] quot_sat(input bit nneg, input logic [65:0] nmag,
                                                  input bit dneg, input logic [65:0] dmag);
    logic [65:0] q;
    if (dmag == 0) return (nmag == 0) ? 32'sd0 : (nneg ? zmp_pkg::SMin : zmp_pkg::SMax);
    q = nmag / dmag;
    if (nneg != dneg) begin
      if (q >= 66'h8000_0000) return zmp_pkg::SMin;
      return -$signed({1'b0, q[30:0]});
    end
    if (q > 66'h7FFF_FFFF) return zmp_pkg::SMax;
    return q[31:0];
  endfunction

  // local centre of pressure rotated and shifted into the world frame
  task automatic world_cop(output logic signed [31:0] wx, output logic signed [31:0] wy);
    logic signed [65:0] tx, ty, fz, cx, cy, rxx, rxy, ryx, ryy, sx, sy;
    tx = torque_x_i;
    ty = torque_y_i;
    fz = normal_force_i;
    rxx = rot_xx_i;
    rxy = rot_xy_i;
    ryx = rot_yx_i;
    ryy = rot_yy_i;
    cx = quot_sat(ty > 0, magnitude(ty) << 16, fz < 0, magnitude(fz));
    cy = quot_sat(tx < 0, magnitude(tx) << 16, fz < 0, magnitude(fz));
    sx = rxx * cx + rxy * cy;
    sy = ryx * cx + ryy * cy;
    wx = clip32(66'(foot_pos_x_i) + (sx >>> 16));
    wy = clip32(66'(foot_pos_y_i) + (sy >>> 16));
  endtask

  function automatic logic signed [31:0] force_average(input logic signed [31:0] a,
      input logic signed [31:0] fa, input logic signed [31:0] b, input logic signed [31:0] fb);
    logic signed [65:0] s, den;
    s = 66'(a) * 66'(fa) + 66'(b) * 66'(fb);
    den = 66'(fa) + 66'(fb);
    return quot_sat(s < 0, magnitude(s), den < 0, magnitude(den));
  endfunction

  function automatic logic signed [31:0] clamp_smooth(input logic signed [31:0] est,
                                                      input logic signed [31:0] target);
    logic signed [65:0] hi, lo, z, e, g;
    e = est;
    z = target;
    hi = e + 66'(half_width);
    lo = e - 66'(half_width);
    g = 66'(gain);
    if (z >= hi) z = hi;
    if (z <= lo) z = lo;
    return clip32(e + ((g * (z - e)) >>> 16));
  endfunction

  // prediction on every accepted item and on register writes
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] rx, ry, zx, zy;
    logic               touch;
    zmp_result_t        res;
    if (!rst_ni) begin
      half_width <= zmp_pkg::ClampResetValue;
      gain       <= zmp_pkg::GainResetValue;
      est_x <= '0;
      est_y <= '0;
      left_x <= '0;
      left_y <= '0;
      left_fz <= '0;
      left_touch <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == zmp_pkg::CfgClampHalfWidth) half_width <= cfg_data_i;
        else if (cfg_index_i == zmp_pkg::CfgSmoothingGain) gain <= cfg_data_i[16:0];
      end
      if (in_valid_i && !in_stall_i) begin
        touch = normal_force_i != 0;
        rx = '0;
        ry = '0;
        if (touch) world_cop(rx, ry);
        if (!foot_side_i) begin
          left_touch <= touch;
          left_fz <= normal_force_i;
          left_x <= rx;
          left_y <= ry;
        end else begin
          if (left_touch && touch) begin
            zx = force_average(left_x, left_fz, rx, normal_force_i);
            zy = force_average(left_y, left_fz, ry, normal_force_i);
          end else if (left_touch) begin
            zx = left_x;
            zy = left_y;
          end else begin
            zx = rx;
            zy = ry;
          end
          res.zx = clamp_smooth(est_x, zx);
          res.zy = clamp_smooth(est_y, zy);
          res.contact = {touch, left_touch};
          est_x <= res.zx;
          est_y <= res.zy;
          zmp_expected_q.push_back(res);
        end
      end
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    zmp_result_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else if (out_valid_i && !out_stall_i) begin
      if (zmp_expected_q.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (fail_count_o < 10) $display("unexpected result x=%0d y=%0d", zmp_x_i, zmp_y_i);
      end else begin
        exp_r = zmp_expected_q.pop_front();
        if (exp_r.zx !== zmp_x_i || exp_r.zy !== zmp_y_i || exp_r.contact !== contact_state_i)
        begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("mismatch: expected x=%0d y=%0d c=%0d, got x=%0d y=%0d c=%0d",
                     exp_r.zx, exp_r.zy, exp_r.contact, zmp_x_i, zmp_y_i, contact_state_i);
        end
      end
    end
  end

  assign pending_o = zmp_expected_q.size();

endmodule

// ===== tb/zmp_from_foot_wrenches_unit_tb.sv =====
// stimulus and verdict for the zero moment point estimator
module zmp_from_foot_wrenches_unit_tb;

  localparam int SettleCycles = 400;
  localparam int CycleLimit = 3000000;

  typedef struct {
    logic        side;
    logic [31:0] tx, ty, fz, px, py;
    logic [17:0] rxx, rxy, ryx, ryy;
  } foot_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = zmp_pkg::CfgClampHalfWidth;
  logic [30:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic foot_side_i = 1'b0;
  logic signed [31:0] torque_x_i = '0, torque_y_i = '0, normal_force_i = '0;
  logic signed [17:0] rot_xx_i = '0, rot_xy_i = '0, rot_yx_i = '0, rot_yy_i = '0;
  logic signed [31:0] foot_pos_x_i = '0, foot_pos_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] zmp_x_o, zmp_y_o;
  logic [1:0] contact_state_o;
  int fail_count, pending;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int cycle_count = 0;

  zmp_from_foot_wrenches_unit DUT (.*);

  zmp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .foot_side_i, .torque_x_i, .torque_y_i,
    .normal_force_i, .rot_xx_i, .rot_xy_i, .rot_yx_i, .rot_yy_i,
    .foot_pos_x_i, .foot_pos_y_i, .out_valid_i(out_valid_o), .out_stall_i,
    .zmp_x_i(zmp_x_o), .zmp_y_i(zmp_y_o), .contact_state_i(contact_state_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mixed-magnitude Q16.16 value
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(2 * 65536 * 64) - 65536 * 64);
      2: return 32'($urandom_range(2 * 65536) - 65536);
      3: return $urandom_range(1) ? zmp_pkg::SMax : zmp_pkg::SMin;
      4: return 32'($urandom_range(2 * 65536 * 4096) - 65536 * 4096);
      default: return 32'($urandom_range(20) - 10);
    endcase
  endfunction

  function automatic logic [17:0] rand_rot();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
    return 18'($urandom_range(131072) - 65536);
  endfunction

  function automatic foot_item_t rand_foot(input logic side);
    foot_item_t it;
    it.side = side;
    it.tx = rand_word();
    it.ty = rand_word();
    it.fz = ($urandom_range(3) == 0) ? 32'd0 : rand_word();
    it.rxx = rand_rot();
    it.rxy = rand_rot();
    it.ryx = rand_rot();
    it.ryy = rand_rot();
    it.px = rand_word();
    it.py = rand_word();
    return it;
  endfunction

  function automatic foot_item_t make_foot(input logic side, input logic [31:0] tx,
      input logic [31:0] ty, input logic [31:0] fz, input logic [17:0] c, input logic [17:0] s,
      input logic [31:0] px, input logic [31:0] py);
    foot_item_t it;
    it = '{side: side, tx: tx, ty: ty, fz: fz, rxx: c, rxy: -s, ryx: s, ryy: c, px: px, py: py};
    return it;
  endfunction

  // hand one item over, with random sender gaps
  task automatic send_foot(input foot_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    foot_side_i <= it.side;
    torque_x_i <= it.tx;
    torque_y_i <= it.ty;
    normal_force_i <= it.fz;
    rot_xx_i <= it.rxx;
    rot_xy_i <= it.rxy;
    rot_yx_i <= it.ryx;
    rot_yy_i <= it.ryy;
    foot_pos_x_i <= it.px;
    foot_pos_y_i <= it.py;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain results and let any left item finish before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [30:0] half_width, input logic [30:0] gain);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= zmp_pkg::CfgClampHalfWidth;
    cfg_data_i <= half_width;
    @(posedge clk_i);
    cfg_index_i <= zmp_pkg::CfgSmoothingGain;
    cfg_data_i <= gain;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_walk(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        // lone right item or repeated left item
        0: begin
          send_foot(rand_foot(1'b1));
          sent++;
        end
        1: begin
          send_foot(rand_foot(1'b0));
          sent++;
        end
        default: begin
          send_foot(rand_foot(1'b0));
          send_foot(rand_foot(1'b1));
          sent += 2;
        end
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: right item with no left item after reset, then the usual cases
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_foot(make_foot(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0040_0000, 18'sd65536, 0,
                        32'h0000_8000, 32'hFFFF_0000));
    send_foot(make_foot(1'b0, 0, 0, 0, 18'sd65536, 0, 0, 0));
    send_foot(make_foot(1'b1, 0, 0, 0, 18'sd65536, 0, 0, 0));
    send_foot(make_foot(1'b0, 32'h0000_4000, -32'sh0000_2000, 32'h0100_0000, 0, 18'sd65536,
                        32'h0000_1000, 32'h0000_2000));
    send_foot(make_foot(1'b1, 0, 0, 0, 0, 0, 0, 0));
    send_foot(make_foot(1'b0, zmp_pkg::SMax, zmp_pkg::SMin, 32'd1, -18'sd65536, 0,
                        zmp_pkg::SMax, zmp_pkg::SMin));
    send_foot(make_foot(1'b0, zmp_pkg::SMin, zmp_pkg::SMax, -32'sd1, 0, -18'sd65536,
                        zmp_pkg::SMin, zmp_pkg::SMax));
    send_foot(make_foot(1'b1, zmp_pkg::SMax, zmp_pkg::SMax, zmp_pkg::SMax, 18'sd65536,
                        18'sd65536, zmp_pkg::SMax, zmp_pkg::SMax));
    // forces cancel
    send_foot(make_foot(1'b0, 32'h0001_0000, 32'h0003_0000, 32'sd500, 18'sd46341, 18'sd46341,
                        32'h0001_0000, 0));
    send_foot(make_foot(1'b1, 32'h0002_0000, -32'sh0001_0000, -32'sd500, 18'sd65536, 0,
                        -32'sh0001_0000, 0));
    send_foot(make_foot(1'b0, 0, 0, 32'sd7, 18'sd65536, 0, 0, 0));
    send_foot(make_foot(1'b1, 0, 0, -32'sd7, 18'sd65536, 0, 0, 0));
    send_foot(make_foot(1'b0, zmp_pkg::SMin, zmp_pkg::SMin, zmp_pkg::SMin, -18'sd65536,
                        -18'sd65536, zmp_pkg::SMin, zmp_pkg::SMin));
    send_foot(make_foot(1'b1, zmp_pkg::SMin, zmp_pkg::SMin, zmp_pkg::SMin, -18'sd65536,
                        18'sd65536, zmp_pkg::SMin, zmp_pkg::SMin));
    send_foot(make_foot(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, -32'sh0002_0000, 18'sd65536, 0,
                        32'h0000_0100, 32'h0000_0200));
    send_foot(make_foot(1'b1, 32'h1234_5678, 32'h8765_4321, 32'h0002_0000, 0, 18'sd65536,
                        32'h0000_0300, -32'sh0000_0400));

    // extremes of both registers, gain above one included
    write_regs(31'h7FFF_FFFF, 31'd65536);
    send_foot(make_foot(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 18'sd65536, 0,
                        zmp_pkg::SMax, zmp_pkg::SMax));
    send_foot(make_foot(1'b1, 0, 0, 0, 0, 0, 0, 0));
    write_regs(31'd0, 31'd0);
    send_foot(make_foot(1'b0, 32'h0001_0000, 0, 32'h0001_0000, 18'sd65536, 0,
                        zmp_pkg::SMin, 0));
    send_foot(make_foot(1'b1, 0, 32'h0001_0000, 32'h0001_0000, 18'sd65536, 0,
                        zmp_pkg::SMax, 0));
    write_regs(31'h0100_0000, 31'd98304);
    send_foot(make_foot(1'b0, 0, 0, 32'h0001_0000, 18'sd65536, 0, 32'h0010_0000, 0));
    send_foot(make_foot(1'b1, 0, 0, 32'h0001_0000, 18'sd65536, 0, 32'h0010_0000, 0));

    // random phases: receiver-heavy idling, sender-heavy, then none
    tx_idle_pct = 37;
    rx_idle_pct = 67;
    write_regs(31'(2294), 31'd16384);
    random_walk(240);
    write_regs(31'($urandom), 31'($urandom_range(65536)));
    random_walk(240);
    tx_idle_pct = 67;
    rx_idle_pct = 37;
    write_regs(31'h7FFF_FFFF, 31'd65536);
    random_walk(240);
    write_regs(31'($urandom_range(1 << 20)), 31'($urandom_range(65536)));
    random_walk(240);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(31'd0, 31'd131071);
    random_walk(120);
    write_regs(31'($urandom), 31'($urandom_range(65536)));
    random_walk(360);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
